/* rtl/bcpg_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// Bezier curve point generator. No dependencies.

package bcpg_pkg;

   localparam int COORD_BITS   = 16;
   localparam int MAX_SEGMENTS = 63;
   localparam int IDX_BITS     = 6;

   // Widths that follow from the segment limit and the coordinate width.
   localparam int SEG_BITS      = $clog2(MAX_SEGMENTS + 1);
   localparam int SQ_BITS       = 2 * SEG_BITS;
   localparam int WEIGHT_BITS   = 3 * SEG_BITS;
   localparam int ACC_BITS      = WEIGHT_BITS + COORD_BITS + 2;
   localparam int CNT_BITS      = $clog2(ACC_BITS);
   localparam int NUM_CTRL      = 4;
   localparam int CTRL_IDX_BITS = $clog2(NUM_CTRL);

   // Curve kinds. Every other code is evaluated as a cubic.
   localparam logic [1:0] KIND_LINE = 2'd0;
   localparam logic [1:0] KIND_QUAD = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WEIGHT_SQ,
      ST_WEIGHT,
      ST_MAC,
      ST_ROUND,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic square;
      logic weight;
      logic mac_step;
      logic div_start;
      logic div_step;
      logic next_point;
   } cmd_type;

   typedef struct packed {
      logic mac_last;
      logic div_last;
      logic point_last;
   } status_type;

endpackage

/* rtl/bcpg_ctrl.sv */
// Sequencing state machine of the Bezier curve point generator.
// Depends on bcpg_pkg for the state type and the command/status structs.

module bcpg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  bcpg_pkg::status_type status,
   output bcpg_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   bcpg_pkg::state_type state_ff;
   bcpg_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcpg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bcpg_pkg::ST_IDLE: begin
            if (start) state_in = bcpg_pkg::ST_WEIGHT_SQ;
         end
         bcpg_pkg::ST_WEIGHT_SQ: state_in = bcpg_pkg::ST_WEIGHT;
         bcpg_pkg::ST_WEIGHT:    state_in = bcpg_pkg::ST_MAC;
         bcpg_pkg::ST_MAC: begin
            if (status.mac_last) state_in = bcpg_pkg::ST_ROUND;
         end
         bcpg_pkg::ST_ROUND:     state_in = bcpg_pkg::ST_DIVIDE;
         bcpg_pkg::ST_DIVIDE: begin
            if (status.div_last) state_in = bcpg_pkg::ST_EMIT;
         end
         bcpg_pkg::ST_EMIT: begin
            if (status.point_last) state_in = bcpg_pkg::ST_IDLE;
            else state_in = bcpg_pkg::ST_WEIGHT_SQ;
         end
         default: state_in = bcpg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == bcpg_pkg::ST_IDLE) && start;
      cmd.square     = (state_ff == bcpg_pkg::ST_WEIGHT_SQ);
      cmd.weight     = (state_ff == bcpg_pkg::ST_WEIGHT);
      cmd.mac_step   = (state_ff == bcpg_pkg::ST_MAC);
      cmd.div_start  = (state_ff == bcpg_pkg::ST_ROUND);
      cmd.div_step   = (state_ff == bcpg_pkg::ST_DIVIDE);
      cmd.next_point = (state_ff == bcpg_pkg::ST_EMIT) && !status.point_last;
      busy           = (state_ff != bcpg_pkg::ST_IDLE);
      rsp_valid      = (state_ff == bcpg_pkg::ST_EMIT);
   end

endmodule

/* rtl/bcpg_datapath.sv */
// Datapath of the Bezier curve point generator: Bernstein weights, a
// multiply-accumulate per axis and a radix-2 rounding divider per axis.
// Depends on bcpg_pkg for widths, curve kinds and the command/status structs.

module bcpg_datapath (
   input  logic                                   clock,
   input  bcpg_pkg::cmd_type                      cmd,
   output bcpg_pkg::status_type                   status,
   input  logic [1:0]                             req_func,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_first_x,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_first_y,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_second_x,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_second_y,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_third_x,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_third_y,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_fourth_x,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_fourth_y,
   input  logic [bcpg_pkg::IDX_BITS-1:0]          req_num_points,
   output logic signed [bcpg_pkg::COORD_BITS-1:0] rsp_point_x,
   output logic signed [bcpg_pkg::COORD_BITS-1:0] rsp_point_y,
   output logic [bcpg_pkg::IDX_BITS-1:0]          rsp_point_index,
   output logic                                   rsp_last
);

   localparam int C  = bcpg_pkg::COORD_BITS;
   localparam int S  = bcpg_pkg::SEG_BITS;
   localparam int Q  = bcpg_pkg::SQ_BITS;
   localparam int W  = bcpg_pkg::WEIGHT_BITS;
   localparam int A  = bcpg_pkg::ACC_BITS;
   localparam int N  = bcpg_pkg::NUM_CTRL;
   localparam int CI = bcpg_pkg::CTRL_IDX_BITS;

   // One restoring step: returns the new remainder above the quotient bit.
   function automatic logic [W:0] div_step_f(input logic [W-1:0] rem, input logic msb,
                                             input logic [W-1:0] den);
      logic [W:0] trial;
      logic [W:0] diff;
      logic [W:0] result;
      trial = {rem, msb};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) result = {diff[W-1:0], 1'b1};
      else result = {trial[W-1:0], 1'b0};
      return result;
   endfunction

   // Applies the sign to the rounded magnitude and clamps to the coordinate range.
   function automatic logic signed [C-1:0] sat_f(input logic neg, input logic [A-1:0] mag);
      logic [A-1:0]     pos_lim;
      logic [C-1:0]     neg_mag;
      logic signed [C-1:0] result;
      pos_lim = {{(A - C + 1){1'b0}}, {(C - 1){1'b1}}};
      neg_mag = -mag[C-1:0];
      if (!neg) begin
         if (mag > pos_lim) result = {1'b0, {(C - 1){1'b1}}};
         else result = mag[C-1:0];
      end else begin
         if (mag > pos_lim + A'(1)) result = {1'b1, {(C - 1){1'b0}}};
         else result = neg_mag;
      end
      return result;
   endfunction

   logic [1:0]          kind_ff;
   logic [S-1:0]        n_ff;
   logic [S-1:0]        k_ff;
   logic signed [C-1:0] px_ff [N];
   logic signed [C-1:0] py_ff [N];
   logic [Q-1:0]        aa_ff, ak_ff, kk_ff, nn_ff;
   logic [W-1:0]        w_ff [N];
   logic [W-1:0]        den_ff;
   logic [CI-1:0]       mac_idx_ff;
   logic signed [A-1:0] acc_x_ff, acc_y_ff;
   logic [A-1:0]        quo_x_ff, quo_y_ff;
   logic [W-1:0]        rem_x_ff, rem_y_ff;
   logic                neg_x_ff, neg_y_ff;
   logic [bcpg_pkg::CNT_BITS-1:0] cnt_ff;

   logic [S-1:0]        n_in;
   logic [S-1:0]        a_val;
   logic [W-1:0]        w_in [N];
   logic [W-1:0]        den_in;
   logic [W-1:0]        cub_ak;
   logic [W-1:0]        cub_kk;
   logic signed [W+C:0] prod_x, prod_y;
   logic signed [A-1:0] acc_x_in, acc_y_in;
   logic [A-1:0]        mag_x, mag_y;
   logic [W:0]          step_x, step_y;

   // Segment count zero means one segment; counts above the limit are clamped.
   always_comb begin
      if (req_num_points == '0) n_in = S'(1);
      else if (req_num_points > bcpg_pkg::IDX_BITS'(bcpg_pkg::MAX_SEGMENTS))
         n_in = S'(bcpg_pkg::MAX_SEGMENTS);
      else n_in = S'(req_num_points);
   end

   assign a_val = n_ff - k_ff;

   always_comb begin
      cub_ak = W'(aa_ff) * W'(k_ff);
      cub_kk = W'(kk_ff) * W'(a_val);
      unique case (kind_ff)
         bcpg_pkg::KIND_LINE: begin
            w_in[0] = W'(a_val);
            w_in[1] = W'(k_ff);
            w_in[2] = '0;
            w_in[3] = '0;
            den_in  = W'(n_ff);
         end
         bcpg_pkg::KIND_QUAD: begin
            w_in[0] = W'(aa_ff);
            w_in[1] = W'(ak_ff) << 1;
            w_in[2] = W'(kk_ff);
            w_in[3] = '0;
            den_in  = W'(nn_ff);
         end
         default: begin
            w_in[0] = W'(aa_ff) * W'(a_val);
            w_in[1] = (cub_ak << 1) + cub_ak;
            w_in[2] = (cub_kk << 1) + cub_kk;
            w_in[3] = W'(kk_ff) * W'(k_ff);
            den_in  = W'(nn_ff) * W'(n_ff);
         end
      endcase
   end

   assign prod_x   = $signed({1'b0, w_ff[mac_idx_ff]}) * px_ff[mac_idx_ff];
   assign prod_y   = $signed({1'b0, w_ff[mac_idx_ff]}) * py_ff[mac_idx_ff];
   assign acc_x_in = acc_x_ff + A'(prod_x);
   assign acc_y_in = acc_y_ff + A'(prod_y);

   // Half the denominator is added to the magnitude so that the truncating
   // divide rounds half away from zero.
   assign mag_x = (acc_x_ff[A-1] ? A'(-acc_x_ff) : A'(acc_x_ff)) + A'(den_ff >> 1);
   assign mag_y = (acc_y_ff[A-1] ? A'(-acc_y_ff) : A'(acc_y_ff)) + A'(den_ff >> 1);

   assign step_x = div_step_f(rem_x_ff, quo_x_ff[A-1], den_ff);
   assign step_y = div_step_f(rem_y_ff, quo_y_ff[A-1], den_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_func;
         n_ff     <= n_in;
         k_ff     <= '0;
         px_ff[0] <= req_first_x;
         py_ff[0] <= req_first_y;
         px_ff[1] <= req_second_x;
         py_ff[1] <= req_second_y;
         px_ff[2] <= req_third_x;
         py_ff[2] <= req_third_y;
         px_ff[3] <= req_fourth_x;
         py_ff[3] <= req_fourth_y;
      end
      if (cmd.next_point) k_ff <= k_ff + S'(1);
      if (cmd.square) begin
         aa_ff <= Q'(a_val) * Q'(a_val);
         ak_ff <= Q'(a_val) * Q'(k_ff);
         kk_ff <= Q'(k_ff) * Q'(k_ff);
         nn_ff <= Q'(n_ff) * Q'(n_ff);
      end
      if (cmd.weight) begin
         for (int i = 0; i < N; i++) w_ff[i] <= w_in[i];
         den_ff     <= den_in;
         acc_x_ff   <= '0;
         acc_y_ff   <= '0;
         mac_idx_ff <= '0;
      end
      if (cmd.mac_step) begin
         acc_x_ff   <= acc_x_in;
         acc_y_ff   <= acc_y_in;
         mac_idx_ff <= mac_idx_ff + CI'(1);
      end
      if (cmd.div_start) begin
         quo_x_ff <= mag_x;
         quo_y_ff <= mag_y;
         rem_x_ff <= '0;
         rem_y_ff <= '0;
         neg_x_ff <= acc_x_ff[A-1];
         neg_y_ff <= acc_y_ff[A-1];
         cnt_ff   <= '0;
      end
      if (cmd.div_step) begin
         quo_x_ff <= {quo_x_ff[A-2:0], step_x[0]};
         quo_y_ff <= {quo_y_ff[A-2:0], step_y[0]};
         rem_x_ff <= step_x[W:1];
         rem_y_ff <= step_y[W:1];
         cnt_ff   <= cnt_ff + bcpg_pkg::CNT_BITS'(1);
      end
   end

   always_comb begin
      status.mac_last   = (mac_idx_ff == CI'(N - 1));
      status.div_last   = (cnt_ff == bcpg_pkg::CNT_BITS'(A - 1));
      status.point_last = (k_ff == n_ff);
   end

   assign rsp_point_x     = sat_f(neg_x_ff, quo_x_ff);
   assign rsp_point_y     = sat_f(neg_y_ff, quo_y_ff);
   assign rsp_point_index = bcpg_pkg::IDX_BITS'(k_ff);
   assign rsp_last        = (k_ff == n_ff);

endmodule

/* rtl/bezier_curve_point_generator.sv */
// Top level of the Bezier curve point generator: controller plus datapath.
// Depends on bcpg_pkg, bcpg_ctrl and bcpg_datapath.
//
//   channel   handshake            payload
//   request   start / busy         req_func, req_*_x/y, req_num_points
//   result    rsp_valid (strobe)   rsp_point_x/y, rsp_point_index, rsp_last
//
// Each point is evaluated in steps: the squares, then the Bernstein weights,
// a multiply-accumulate over the four control points, the rounded
// magnitude, the bit-per-cycle divider and the result strobe.
// A request with n segments keeps busy high until all n + 1 points are shown.
// Reset returns the controller to idle; a curve in progress is dropped.
// The receiver cannot stall: each point is shown for exactly one cycle.

module bezier_curve_point_generator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_func,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_first_x,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_first_y,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_second_x,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_second_y,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_third_x,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_third_y,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_fourth_x,
   input  logic signed [bcpg_pkg::COORD_BITS-1:0] req_fourth_y,
   input  logic [bcpg_pkg::IDX_BITS-1:0]          req_num_points,
   output logic                                   rsp_valid,
   output logic signed [bcpg_pkg::COORD_BITS-1:0] rsp_point_x,
   output logic signed [bcpg_pkg::COORD_BITS-1:0] rsp_point_y,
   output logic [bcpg_pkg::IDX_BITS-1:0]          rsp_point_index,
   output logic                                   rsp_last
);

   bcpg_pkg::cmd_type    cmd;
   bcpg_pkg::status_type status;

   bcpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bcpg_datapath u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_func),
      .req_first_x     (req_first_x),
      .req_first_y     (req_first_y),
      .req_second_x    (req_second_x),
      .req_second_y    (req_second_y),
      .req_third_x     (req_third_x),
      .req_third_y     (req_third_y),
      .req_fourth_x    (req_fourth_x),
      .req_fourth_y    (req_fourth_y),
      .req_num_points  (req_num_points),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_index (rsp_point_index),
      .rsp_last        (rsp_last)
   );

   // A point is only ever shown while a request is being worked on.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result strobe while idle");

   // The final point of a curve releases the block in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_last |=> !busy)
      else $error("block still busy after the final point");

   // Points are spaced by a full evaluation, never in adjacent cycles.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("two result strobes in a row");

   // An accepted request yields its first point, index zero, after the full evaluation.
   assert property (@(posedge clock) disable iff (reset)
                    start && !busy |-> ##44 (rsp_valid && rsp_point_index == '0))
      else $error("first point missing or misnumbered");

endmodule
